FILE: hw/rtl/incremental_pid_step_defines.svh
// Assertion macros for the checker file of the PID step block.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef INCREMENTAL_PID_STEP_DEFINES_SVH
`define INCREMENTAL_PID_STEP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define IPID_ASSERT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define IPID_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/ipid_pkg.sv
// Shared widths, register codes and stage beat types of the PID step block.
// No dependencies.
package ipid_pkg;

    localparam int COEF_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int PROD_W   = COEF_W + SAMPLE_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int ACCUM_W  = 32;
    localparam int ACC_W    = SUM_W + 1;
    localparam int DRIVE_W  = 16;
    localparam int SHIFT    = 16;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -ACC_MAX;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } coef_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] e;
        logic signed [SAMPLE_W-1:0] e1;
        logic signed [SAMPLE_W-1:0] e2;
    } err_beat_t;

    typedef struct packed {
        logic                     valid;
        logic signed [SUM_W-1:0]  sum;
    } sum_beat_t;

endpackage

FILE: hw/rtl/ipid_regs.sv
// Coefficient registers behind the APB-style configuration port.
// Depends on ipid_pkg.
module ipid_regs (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ipid_pkg::PADDR_W-1:0] paddr,
    input  logic [ipid_pkg::PDATA_W-1:0] pwdata,
    output logic [ipid_pkg::PDATA_W-1:0] prdata,
    output logic                    pready,
    output ipid_pkg::coef_t         coef
);
    import ipid_pkg::*;

    coef_t coef_reg;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign coef   = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_COEF_A: coef_reg.a <= pwdata;
                REG_COEF_B: coef_reg.b <= pwdata;
                REG_COEF_C: coef_reg.c <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COEF_A: prdata = coef_reg.a;
            REG_COEF_B: prdata = coef_reg.b;
            REG_COEF_C: prdata = coef_reg.c;
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/ipid_err.sv
// Input stage: error of the accepted beat and the two-deep error history.
// Depends on ipid_pkg.
module ipid_err (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [ipid_pkg::SAMPLE_W-1:0] setpoint,
    input  logic [ipid_pkg::SAMPLE_W-1:0] measured,
    output ipid_pkg::err_beat_t           beat
);
    import ipid_pkg::*;

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] e_reg;
    logic signed [SAMPLE_W-1:0] e1_reg;
    logic signed [SAMPLE_W-1:0] e2_reg;
    logic signed [SAMPLE_W-1:0] e_next;

    assign e_next = setpoint - measured;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            e_reg     <= '0;
            e1_reg    <= '0;
            e2_reg    <= '0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
            if (in_valid)
            begin
                e_reg  <= e_next;
                e1_reg <= e_reg;
                e2_reg <= e1_reg;
            end
        end
    end

    assign beat.valid = valid_reg;
    assign beat.e     = e_reg;
    assign beat.e1    = e1_reg;
    assign beat.e2    = e2_reg;

endmodule

FILE: hw/rtl/ipid_mac.sv
// Product stage and sum-of-products stage of the PID step.
// Depends on ipid_pkg.
module ipid_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  ipid_pkg::coef_t     coef,
    input  ipid_pkg::err_beat_t err,
    output ipid_pkg::sum_beat_t beat
);
    import ipid_pkg::*;

    logic                     pv_reg;
    logic signed [PROD_W-1:0] pa_reg;
    logic signed [PROD_W-1:0] pb_reg;
    logic signed [PROD_W-1:0] pc_reg;
    logic signed [PROD_W-1:0] pa_next;
    logic signed [PROD_W-1:0] pb_next;
    logic signed [PROD_W-1:0] pc_next;
    logic                     sv_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;

    assign pa_next = $signed(coef.a) * $signed(err.e);
    assign pb_next = $signed(coef.b) * $signed(err.e1);
    assign pc_next = $signed(coef.c) * $signed(err.e2);

    assign sum_next = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else if (adv)
        begin
            pv_reg <= err.valid;
            sv_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg  <= pa_next;
            pb_reg  <= pb_next;
            pc_reg  <= pc_next;
            sum_reg <= sum_next;
        end
    end

    assign beat.valid = sv_reg;
    assign beat.sum   = sum_reg;

endmodule

FILE: hw/rtl/ipid_acc.sv
// Accumulate stage: add to the previous output, saturate, hold the result beat.
// Depends on ipid_pkg.
module ipid_acc (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  ipid_pkg::sum_beat_t          sum,
    output logic                         out_valid,
    output logic [ipid_pkg::DRIVE_W-1:0] drive
);
    import ipid_pkg::*;

    logic                      out_valid_reg;
    logic signed [ACCUM_W-1:0] accum_reg;
    logic        [DRIVE_W-1:0] drive_reg;
    logic signed [ACC_W-1:0]   total;
    logic signed [ACC_W-1:0]   sat;

    assign total = ACC_W'(sum.sum) + ACC_W'(accum_reg);

    always_comb
    begin
        if (total > ACC_MAX)
            sat = ACC_MAX;
        else if (total < ACC_MIN)
            sat = ACC_MIN;
        else
            sat = total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            accum_reg     <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= sum.valid;
            if (sum.valid)
                accum_reg <= sat[ACCUM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && sum.valid)
            drive_reg <= sat[SHIFT+DRIVE_W-1:SHIFT];
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

FILE: hw/rtl/incremental_pid_step.sv
// Incremental (velocity-form) PID step, fixed point.
// Depends on ipid_pkg, ipid_regs, ipid_err, ipid_mac, ipid_acc.
//
// Usage:
//   Slave stream (s_*) takes one sample per beat: setpoint and measured value.
//   Master stream (m_*) gives one drive value per accepted sample, in order.
//   The APB port holds coef_a, coef_b, coef_c at byte addresses 0, 4, 8;
//   write them only while no sample is in flight.
// Pipeline: a drive beat is presented once its sample has passed the input
//   register (loaded at the edge that takes the sample), then the product,
//   sum and accumulate registers.
// Throughput: one sample per cycle while the output is not stalled; the
//   accumulate add and saturate close the only loop, through accum_reg.
// Stall: all stages advance together; while the output register holds an
//   untaken beat, s_tready drops and every stage holds.
// Reset: coefficients, previous output and error history clear to zero,
//   no beat is in flight.
module incremental_pid_step (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // setpoint[15:0], measured[31:16]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // drive[15:0]
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ipid_pkg::PADDR_W-1:0] paddr,
    input  logic [ipid_pkg::PDATA_W-1:0] pwdata,
    output logic [ipid_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import ipid_pkg::*;

    coef_t     coef;
    err_beat_t err_beat;
    sum_beat_t sum_beat;
    logic      adv;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    ipid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    ipid_err u_err (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_tvalid),
        .setpoint (s_tdata[SAMPLE_W-1:0]),
        .measured (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .beat     (err_beat)
    );

    ipid_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .coef  (coef),
        .err   (err_beat),
        .beat  (sum_beat)
    );

    ipid_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .sum       (sum_beat),
        .out_valid (m_tvalid),
        .drive     (m_tdata)
    );

endmodule

FILE: hw/rtl/ipid_checker.sv
// Port-level checks of the PID step block, bound to the top level.
// Depends on ipid_pkg and incremental_pid_step_defines.svh.
`include "incremental_pid_step_defines.svh"

module ipid_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [15:0]                  m_tdata,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [ipid_pkg::PADDR_W-1:0] paddr,
    input logic [ipid_pkg::PDATA_W-1:0] pwdata,
    input logic [ipid_pkg::PDATA_W-1:0] prdata,
    input logic                         pready
);
    import ipid_pkg::*;

    `IPID_ASSERT(a_ready_only_on_stall, !s_tready, m_tvalid && !m_tready,
        "input stalled without output stall")
    `IPID_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "stalled output beat changed")
    `IPID_ASSERT_NEXT(a_coef_a_readback,
        psel && penable && pwrite && pready && paddr[3:2] == REG_COEF_A,
        paddr[3:2] != REG_COEF_A || prdata == $past(pwdata), "coef_a readback mismatch")
    `IPID_ASSERT(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind incremental_pid_step ipid_checker u_ipid_checker (.*);

FILE: test/tb_incremental_pid_step.sv
// Self-checking bench for the incremental PID step: streams setpoint/measured beats, predicts
// each drive value from its own copy of gains and loop state, and checks every output beat.
// Depends on ipid_pkg and the incremental_pid_step RTL.
module tb_incremental_pid_step;
    import ipid_pkg::*;

    localparam logic [1:0]   REG_SPARE = 2'd3;
    localparam longint       SAT_LIMIT = 64'sd2147483647;
    localparam logic [31:0]  GAIN_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0]  GAIN_MIN  = 32'h8000_0000;
    localparam logic [31:0]  GAIN_NEG  = 32'h8000_0001;
    localparam logic [31:0]  GAIN_ONE  = 32'h0001_0000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;    // setpoint[15:0], measured[31:16]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;         // drive[15:0]
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    logic signed [31:0]   gain_a = '0;
    logic signed [31:0]   gain_b = '0;
    logic signed [31:0]   gain_c = '0;
    logic signed [31:0]   acc_state = '0;
    logic signed [15:0]   err_d1 = '0;
    logic signed [15:0]   err_d2 = '0;

    logic [15:0]          expected_drive[$];
    int                   mismatches = 0;
    int                   src_idle_pct = 0;
    int                   sink_stall_pct = 0;

    incremental_pid_step DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] pid_update(input logic signed [15:0] sp,
                                               input logic signed [15:0] mv);
        logic signed [15:0] err;
        longint             total;
        err = sp - mv;
        total = longint'(acc_state) + longint'(gain_a) * longint'(err)
              + longint'(gain_b) * longint'(err_d1) + longint'(gain_c) * longint'(err_d2);
        if (total > SAT_LIMIT)
            total = SAT_LIMIT;
        else if (total < -SAT_LIMIT)
            total = -SAT_LIMIT;
        err_d2 = err_d1;
        err_d1 = err;
        acc_state = total[31:0];
        return total[31:16];
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, actual %h", what, want, got);
    endtask

    always @(posedge clk)
    begin : drive_checker
        logic [15:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_drive.size() == 0)
                note_mismatch("unexpected drive beat", 32'hx, {16'h0, m_tdata});
            else
            begin
                want = expected_drive.pop_front();
                if (m_tdata !== want)
                    note_mismatch("drive", {16'h0, want}, {16'h0, m_tdata});
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_sample(input logic [15:0] sp, input logic [15:0] mv);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mv, sp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_drive.push_back(pid_update(sp, mv));
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] value, output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (wr)
        begin
            case (idx)
                REG_COEF_A: gain_a = value;
                REG_COEF_B: gain_b = value;
                REG_COEF_C: gain_c = value;
                default: ;
            endcase
        end
    endtask

    task automatic check_gains();
        logic [31:0] rd;
        apb_access(1'b0, REG_COEF_A, '0, rd);
        if (rd !== gain_a) note_mismatch("coef_a readback", gain_a, rd);
        apb_access(1'b0, REG_COEF_B, '0, rd);
        if (rd !== gain_b) note_mismatch("coef_b readback", gain_b, rd);
        apb_access(1'b0, REG_COEF_C, '0, rd);
        if (rd !== gain_c) note_mismatch("coef_c readback", gain_c, rd);
    endtask

    task automatic set_gains(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        logic [31:0] rd;
        drain_pipeline();
        apb_access(1'b1, REG_COEF_A, a, rd);
        apb_access(1'b1, REG_COEF_B, b, rd);
        apb_access(1'b1, REG_COEF_C, c, rd);
        check_gains();
    endtask

    function automatic logic [31:0] pick_gain();
        logic [31:0] mag;
        case ($urandom_range(9))
            0: return GAIN_MAX;
            1: return GAIN_MIN;
            2: return GAIN_NEG;
            3: return '0;
            4: return $urandom;
            default:
            begin
                mag = $urandom >> $urandom_range(31, 12);
                return $urandom_range(1) ? -mag : mag;
            end
        endcase
    endfunction

    task automatic test_zero_gains();
        check_gains();
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'h0001);
    endtask

    task automatic test_unit_gain_wrap();
        set_gains(GAIN_ONE, '0, '0);
        // error wraps to -1 and +1
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        // climb into positive saturation, then back down into negative
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h8000, 16'h0000);
    endtask

    task automatic test_history_extremes();
        set_gains('0, GAIN_MAX, GAIN_MIN);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h7FFF);
        send_sample(16'h0123, 16'h0100);
        set_gains(GAIN_MIN, GAIN_NEG, GAIN_MAX);
        send_sample(16'h8000, 16'h0000);
        send_sample(16'h7FFF, 16'h0000);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_spare_register();
        logic [31:0] rd;
        set_gains(32'h0000_4000, 32'hFFFF_E000, 32'h0000_1000);
        apb_access(1'b1, REG_SPARE, 32'hFFFF_FFFF, rd);
        check_gains();
        send_sample(16'h1000, 16'h0F00);
        send_sample(16'hF000, 16'h0100);
        send_sample(16'h0010, 16'h0020);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int sets, input int per_set);
        logic [15:0] sp;
        logic [15:0] mv;
        drain_pipeline();
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int s = 0; s < sets; s++)
        begin
            set_gains(pick_gain(), pick_gain(), pick_gain());
            for (int n = 0; n < per_set; n++)
            begin
                sp = 16'($urandom);
                if ($urandom_range(2) == 0)
                    mv = 16'($urandom);
                else
                    mv = sp + 16'($signed($urandom_range(512)) - 256);
                send_sample(sp, mv);
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_gains();
        test_unit_gain_wrap();
        test_history_extremes();
        test_spare_register();
        test_random_phase(0, 0, 4, 105);
        test_random_phase(45, 0, 4, 105);
        test_random_phase(0, 45, 4, 105);
        test_random_phase(31, 31, 4, 105);
        drain_pipeline();
        if (mismatches == 0 && expected_drive.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
